// ----- design/im2col_pkg.sv -----
package im2col_pkg;

  // Fixed field widths of the result word.
  localparam int FIELD_W     = 8;
  localparam int ADDR_W      = 24;
  localparam int LOWER_W     = 16;

  // Configuration port.
  localparam int CFG_DATA_W  = 9;
  localparam int CFG_INDEX_W = 3;
  localparam int MAP_REG_W   = 9;
  localparam int KERN_REG_W  = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAP_HEIGHT    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAP_WIDTH     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_ROWS   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_COLS   = 3'd4;

  // Default sizing of the walk counters.
  localparam int DEF_MAX_CHANNELS   = 256;
  localparam int DEF_MAX_MAP_DIM    = 256;
  localparam int DEF_MAX_KERNEL_DIM = 16;

  // One element between the walk stage and the address stage.
  typedef struct packed {
    logic [FIELD_W-1:0] src_channel;
    logic [FIELD_W-1:0] src_row;
    logic [FIELD_W-1:0] src_col;
    logic [ADDR_W-1:0]  addr_base;
    logic [ADDR_W-1:0]  addr_col;
    logic [LOWER_W-1:0] dst_row;
    logic [LOWER_W-1:0] dst_col;
    logic               patch_done;
    logic               matrix_done;
    logic               config_error;
  } elem_t;

endpackage

// ----- design/im2col_cfg.sv -----
module im2col_cfg #(
  parameter int MAX_CHANNELS   = im2col_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_MAP_DIM    = im2col_pkg::DEF_MAX_MAP_DIM,
  parameter int MAX_KERNEL_DIM = im2col_pkg::DEF_MAX_KERNEL_DIM,
  localparam int CHW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int DIMW = $clog2(MAX_MAP_DIM),
  localparam int HW   = $clog2(MAX_MAP_DIM + 1),
  localparam int KW   = (MAX_KERNEL_DIM > 1) ? $clog2(MAX_KERNEL_DIM) : 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [im2col_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [im2col_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic [CHW-1:0]                     chan_last,
  output logic [HW-1:0]                      map_h,
  output logic [HW-1:0]                      map_w,
  output logic [KW-1:0]                      kr_last,
  output logic [KW-1:0]                      kc_last,
  output logic [DIMW-1:0]                    orow_last,
  output logic [DIMW-1:0]                    ocol_last,
  output logic                               config_error
);

  logic [im2col_pkg::MAP_REG_W-1:0]  channel_count;
  logic [im2col_pkg::MAP_REG_W-1:0]  map_height;
  logic [im2col_pkg::MAP_REG_W-1:0]  map_width;
  logic [im2col_pkg::KERN_REG_W-1:0] kernel_rows;
  logic [im2col_pkg::KERN_REG_W-1:0] kernel_cols;

  logic [31:0] ch_c, h_c, w_c, kr_c, kc_c;

  // A zero register acts as one; a value above the maximum saturates.
  function automatic logic [31:0] clamp_dim(input logic [31:0] v, input logic [31:0] hi);
    logic [31:0] r;
    if (v == 32'd0) begin
      r = 32'd1;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= im2col_pkg::MAP_REG_W'(1);
      map_height    <= im2col_pkg::MAP_REG_W'(1);
      map_width     <= im2col_pkg::MAP_REG_W'(1);
      kernel_rows   <= im2col_pkg::KERN_REG_W'(1);
      kernel_cols   <= im2col_pkg::KERN_REG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        im2col_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data[im2col_pkg::MAP_REG_W-1:0];
        im2col_pkg::REG_MAP_HEIGHT:    map_height    <= cfg_data[im2col_pkg::MAP_REG_W-1:0];
        im2col_pkg::REG_MAP_WIDTH:     map_width     <= cfg_data[im2col_pkg::MAP_REG_W-1:0];
        im2col_pkg::REG_KERNEL_ROWS:   kernel_rows   <= cfg_data[im2col_pkg::KERN_REG_W-1:0];
        im2col_pkg::REG_KERNEL_COLS:   kernel_cols   <= cfg_data[im2col_pkg::KERN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ch_c = clamp_dim(32'(channel_count), 32'(MAX_CHANNELS));
    h_c  = clamp_dim(32'(map_height), 32'(MAX_MAP_DIM));
    w_c  = clamp_dim(32'(map_width), 32'(MAX_MAP_DIM));
    kr_c = clamp_dim(32'(kernel_rows), 32'(MAX_KERNEL_DIM));
    kc_c = clamp_dim(32'(kernel_cols), 32'(MAX_KERNEL_DIM));
  end

  assign chan_last    = CHW'(ch_c - 32'd1);
  assign map_h        = HW'(h_c);
  assign map_w        = HW'(w_c);
  assign kr_last      = KW'(kr_c - 32'd1);
  assign kc_last      = KW'(kc_c - 32'd1);
  // With the kernel larger than the map, one output position remains on that axis.
  assign orow_last    = (h_c >= kr_c) ? DIMW'(h_c - kr_c) : '0;
  assign ocol_last    = (w_c >= kc_c) ? DIMW'(w_c - kc_c) : '0;
  assign config_error = (kr_c > h_c) || (kc_c > w_c);

endmodule

// ----- design/im2col_walk.sv -----
module im2col_walk #(
  parameter int MAX_CHANNELS   = im2col_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_MAP_DIM    = im2col_pkg::DEF_MAX_MAP_DIM,
  parameter int MAX_KERNEL_DIM = im2col_pkg::DEF_MAX_KERNEL_DIM,
  localparam int CHW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int DIMW = $clog2(MAX_MAP_DIM),
  localparam int HW   = $clog2(MAX_MAP_DIM + 1),
  localparam int KW   = (MAX_KERNEL_DIM > 1) ? $clog2(MAX_KERNEL_DIM) : 1,
  localparam int SRW  = ((DIMW > KW) ? DIMW : KW) + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              restart,
  input  logic [CHW-1:0]    chan_last,
  input  logic [HW-1:0]     map_h,
  input  logic [KW-1:0]     kr_last,
  input  logic [KW-1:0]     kc_last,
  input  logic [DIMW-1:0]   orow_last,
  input  logic [DIMW-1:0]   ocol_last,
  input  logic              config_error,
  output logic              s1_valid,
  output im2col_pkg::elem_t s1_elem,
  input  logic              s1_take
);

  logic [DIMW-1:0]                  out_row_count, out_row_count_next;
  logic [DIMW-1:0]                  out_col_count, out_col_count_next;
  logic [CHW-1:0]                   chan_count, chan_count_next;
  logic [KW-1:0]                    kern_row_count, kern_row_count_next;
  logic [KW-1:0]                    kern_col_count, kern_col_count_next;
  logic [im2col_pkg::LOWER_W-1:0]   lowered_row_count, lowered_row_count_next;
  logic [im2col_pkg::LOWER_W-1:0]   lowered_col_count, lowered_col_count_next;

  logic [DIMW-1:0]                  cur_or, cur_oc;
  logic [CHW-1:0]                   cur_ch;
  logic [KW-1:0]                    cur_kr, cur_kc;
  logic [im2col_pkg::LOWER_W-1:0]   cur_lrow, cur_lcol;
  logic                             last_kc, last_kr, last_ch, last_oc, last_or;
  logic                             pdone, mdone;
  logic [SRW-1:0]                   srow, scol;
  logic [CHW+HW-1:0]                prod;
  logic                             in_fire;
  im2col_pkg::elem_t                elem_next;

  assign in_ready = !s1_valid || s1_take;
  assign in_fire  = in_valid && in_ready;

  // A restart word is served from the first element.
  always_comb begin
    cur_or   = restart ? '0 : out_row_count;
    cur_oc   = restart ? '0 : out_col_count;
    cur_ch   = restart ? '0 : chan_count;
    cur_kr   = restart ? '0 : kern_row_count;
    cur_kc   = restart ? '0 : kern_col_count;
    cur_lrow = restart ? '0 : lowered_row_count;
    cur_lcol = restart ? '0 : lowered_col_count;

    // At or beyond the last value counts as last, so a shrunk geometry wraps.
    last_kc = cur_kc >= kc_last;
    last_kr = cur_kr >= kr_last;
    last_ch = cur_ch >= chan_last;
    last_oc = cur_oc >= ocol_last;
    last_or = cur_or >= orow_last;
    pdone   = last_kc && last_kr && last_ch;
    mdone   = pdone && last_oc && last_or;

    srow = SRW'(cur_or) + SRW'(cur_kr);
    scol = SRW'(cur_oc) + SRW'(cur_kc);
    prod = (CHW+HW)'(cur_ch) * (CHW+HW)'(map_h);

    elem_next.src_channel  = im2col_pkg::FIELD_W'(cur_ch);
    elem_next.src_row      = im2col_pkg::FIELD_W'(srow);
    elem_next.src_col      = im2col_pkg::FIELD_W'(scol);
    elem_next.addr_base    = im2col_pkg::ADDR_W'(prod) + im2col_pkg::ADDR_W'(srow);
    elem_next.addr_col     = im2col_pkg::ADDR_W'(scol);
    elem_next.dst_row      = cur_lrow;
    elem_next.dst_col      = cur_lcol;
    elem_next.patch_done   = pdone;
    elem_next.matrix_done  = mdone;
    elem_next.config_error = config_error;

    out_row_count_next     = cur_or;
    out_col_count_next     = cur_oc;
    chan_count_next        = cur_ch;
    kern_row_count_next    = cur_kr;
    kern_col_count_next    = cur_kc;
    lowered_row_count_next = cur_lrow;
    lowered_col_count_next = cur_lcol;

    if (mdone) begin
      out_row_count_next     = '0;
      out_col_count_next     = '0;
      chan_count_next        = '0;
      kern_row_count_next    = '0;
      kern_col_count_next    = '0;
      lowered_row_count_next = '0;
      lowered_col_count_next = '0;
    end else if (pdone) begin
      kern_col_count_next    = '0;
      kern_row_count_next    = '0;
      chan_count_next        = '0;
      lowered_row_count_next = '0;
      lowered_col_count_next = cur_lcol + im2col_pkg::LOWER_W'(1);
      if (last_oc) begin
        out_col_count_next = '0;
        out_row_count_next = cur_or + DIMW'(1);
      end else begin
        out_col_count_next = cur_oc + DIMW'(1);
      end
    end else begin
      lowered_row_count_next = cur_lrow + im2col_pkg::LOWER_W'(1);
      if (!last_kc) begin
        kern_col_count_next = cur_kc + KW'(1);
      end else begin
        kern_col_count_next = '0;
        if (!last_kr) begin
          kern_row_count_next = cur_kr + KW'(1);
        end else begin
          kern_row_count_next = '0;
          chan_count_next     = cur_ch + CHW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_row_count     <= '0;
      out_col_count     <= '0;
      chan_count        <= '0;
      kern_row_count    <= '0;
      kern_col_count    <= '0;
      lowered_row_count <= '0;
      lowered_col_count <= '0;
      s1_valid          <= 1'b0;
    end else begin
      if (in_fire) begin
        out_row_count     <= out_row_count_next;
        out_col_count     <= out_col_count_next;
        chan_count        <= chan_count_next;
        kern_row_count    <= kern_row_count_next;
        kern_col_count    <= kern_col_count_next;
        lowered_row_count <= lowered_row_count_next;
        lowered_col_count <= lowered_col_count_next;
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_elem <= elem_next;
    end
  end

`ifndef ASSERT_OFF
  a_mdone_in_patch: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (!s1_elem.matrix_done || s1_elem.patch_done))
    else $error("matrix end flagged outside a patch end");

  a_restart_first: assert property (@(posedge clk) disable iff (rst)
    (in_fire && restart) |=> (s1_elem.dst_row == '0 && s1_elem.dst_col == '0
                              && s1_elem.src_channel == '0))
    else $error("restart word did not start at the first element");

  a_wrap_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && mdone) |=> (chan_count == '0 && kern_row_count == '0 &&
                            kern_col_count == '0 && lowered_row_count == '0 &&
                            lowered_col_count == '0 && out_row_count == '0))
    else $error("walk did not wrap after the last element");
`endif

endmodule

// ----- design/im2col_addr.sv -----
module im2col_addr #(
  parameter int MAX_MAP_DIM = im2col_pkg::DEF_MAX_MAP_DIM,
  localparam int HW = $clog2(MAX_MAP_DIM + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s1_valid,
  input  im2col_pkg::elem_t                s1_elem,
  output logic                             s1_take,
  input  logic [HW-1:0]                    map_w,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [im2col_pkg::FIELD_W-1:0]   src_channel,
  output logic [im2col_pkg::FIELD_W-1:0]   src_row,
  output logic [im2col_pkg::FIELD_W-1:0]   src_col,
  output logic [im2col_pkg::ADDR_W-1:0]    src_address,
  output logic [im2col_pkg::LOWER_W-1:0]   dst_row,
  output logic [im2col_pkg::LOWER_W-1:0]   dst_col,
  output logic                             patch_done,
  output logic                             matrix_done,
  output logic                             config_error
);

  im2col_pkg::elem_t               ob;
  logic [im2col_pkg::ADDR_W-1:0]   addr_q;
  logic [im2col_pkg::ADDR_W-1:0]   row_prod;

  assign s1_take  = s1_valid && (!out_valid || out_ready);
  // Flat address: (channel*height + row)*width + column, kept modulo the field width.
  assign row_prod = s1_elem.addr_base * im2col_pkg::ADDR_W'(map_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      ob     <= s1_elem;
      addr_q <= row_prod + s1_elem.addr_col;
    end
  end

  assign src_channel  = ob.src_channel;
  assign src_row      = ob.src_row;
  assign src_col      = ob.src_col;
  assign src_address  = addr_q;
  assign dst_row      = ob.dst_row;
  assign dst_col      = ob.dst_col;
  assign patch_done   = ob.patch_done;
  assign matrix_done  = ob.matrix_done;
  assign config_error = ob.config_error;

endmodule

// ----- design/im2col_patch_address_generator_top.sv -----
// im2col patch address generator.
// Each word on the input channel (in_valid/in_ready, field restart) yields one
// result word on the output channel (out_valid/out_ready): the source channel,
// row, column and flat address of one feature map element, its row and column
// in the lowered matrix, and patch end, matrix end and configuration error flags.
// The walk goes output row, output column, channel, kernel row, kernel column and
// wraps after the last element; a word with restart set is served from the first
// element. Configuration words (cfg_valid/cfg_ready, cfg_index, cfg_data) are
// always taken and must be written while no word is in flight.
// An accepted input word is held in the walk stage register, then its result in the
// output register: the walk stage registers the element and the channel*height
// product, the address stage multiplies by the width. Throughput is one word per
// cycle while out_ready is high. When the receiver stalls, results hold in the
// output register and the walk stage, so up to two words are buffered before
// in_ready drops. Reset clears the walk to the first element, empties both stages
// and sets every configuration register to one.
module im2col_patch_address_generator_top #(
  parameter int MAX_CHANNELS   = im2col_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_MAP_DIM    = im2col_pkg::DEF_MAX_MAP_DIM,
  parameter int MAX_KERNEL_DIM = im2col_pkg::DEF_MAX_KERNEL_DIM
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [im2col_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [im2col_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               restart,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [im2col_pkg::FIELD_W-1:0]     src_channel,
  output logic [im2col_pkg::FIELD_W-1:0]     src_row,
  output logic [im2col_pkg::FIELD_W-1:0]     src_col,
  output logic [im2col_pkg::ADDR_W-1:0]      src_address,
  output logic [im2col_pkg::LOWER_W-1:0]     dst_row,
  output logic [im2col_pkg::LOWER_W-1:0]     dst_col,
  output logic                               patch_done,
  output logic                               matrix_done,
  output logic                               config_error
);

  localparam int CHW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int DIMW = $clog2(MAX_MAP_DIM);
  localparam int HW   = $clog2(MAX_MAP_DIM + 1);
  localparam int KW   = (MAX_KERNEL_DIM > 1) ? $clog2(MAX_KERNEL_DIM) : 1;

  logic [CHW-1:0]    chan_last;
  logic [HW-1:0]     map_h, map_w;
  logic [KW-1:0]     kr_last, kc_last;
  logic [DIMW-1:0]   orow_last, ocol_last;
  logic              geom_error;
  logic              s1_valid, s1_take;
  im2col_pkg::elem_t s1_elem;

  im2col_cfg #(
    .MAX_CHANNELS   (MAX_CHANNELS),
    .MAX_MAP_DIM    (MAX_MAP_DIM),
    .MAX_KERNEL_DIM (MAX_KERNEL_DIM)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .chan_last    (chan_last),
    .map_h        (map_h),
    .map_w        (map_w),
    .kr_last      (kr_last),
    .kc_last      (kc_last),
    .orow_last    (orow_last),
    .ocol_last    (ocol_last),
    .config_error (geom_error)
  );

  im2col_walk #(
    .MAX_CHANNELS   (MAX_CHANNELS),
    .MAX_MAP_DIM    (MAX_MAP_DIM),
    .MAX_KERNEL_DIM (MAX_KERNEL_DIM)
  ) u_walk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .restart      (restart),
    .chan_last    (chan_last),
    .map_h        (map_h),
    .kr_last      (kr_last),
    .kc_last      (kc_last),
    .orow_last    (orow_last),
    .ocol_last    (ocol_last),
    .config_error (geom_error),
    .s1_valid     (s1_valid),
    .s1_elem      (s1_elem),
    .s1_take      (s1_take)
  );

  im2col_addr #(
    .MAX_MAP_DIM (MAX_MAP_DIM)
  ) u_addr (
    .clk          (clk),
    .rst          (rst),
    .s1_valid     (s1_valid),
    .s1_elem      (s1_elem),
    .s1_take      (s1_take),
    .map_w        (map_w),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .src_channel  (src_channel),
    .src_row      (src_row),
    .src_col      (src_col),
    .src_address  (src_address),
    .dst_row      (dst_row),
    .dst_col      (dst_col),
    .patch_done   (patch_done),
    .matrix_done  (matrix_done),
    .config_error (config_error)
  );

`ifndef ASSERT_OFF
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while the output side drains");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int RANDOM_WORDS   = 1250;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int STALL_CYCLES   = 60;
  localparam logic [im2col_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [im2col_pkg::FIELD_W-1:0] src_channel;
    logic [im2col_pkg::FIELD_W-1:0] src_row;
    logic [im2col_pkg::FIELD_W-1:0] src_col;
    logic [im2col_pkg::ADDR_W-1:0]  src_address;
    logic [im2col_pkg::LOWER_W-1:0] dst_row;
    logic [im2col_pkg::LOWER_W-1:0] dst_col;
    logic                           patch_done;
    logic                           matrix_done;
    logic                           config_error;
  } gather_elem_t;

  typedef struct packed {
    bit                                 is_cfg;
    logic [im2col_pkg::CFG_INDEX_W-1:0] idx;
    logic [im2col_pkg::CFG_DATA_W-1:0]  data;
    bit                                 from_start;
    bit                                 typed;
    gather_elem_t                       want;
  } stim_row_t;

  // First element of a 1x1 walk: it is the whole matrix.
  localparam gather_elem_t ORIGIN_ELEM =
    '{8'd0, 8'd0, 8'd0, 24'd0, 16'd0, 16'd0, 1'b1, 1'b1, 1'b0};
  // Two-row kernel over a one-row map: both kernel rows are still walked.
  localparam gather_elem_t TALL_TOP_ELEM =
    '{8'd0, 8'd0, 8'd0, 24'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b1};
  localparam gather_elem_t TALL_BOTTOM_ELEM =
    '{8'd0, 8'd1, 8'd0, 24'd1, 16'd1, 16'd0, 1'b1, 1'b1, 1'b1};
  localparam gather_elem_t NO_ELEM = '0;

  logic                               clk;
  logic                               rst;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [im2col_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [im2col_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                               in_valid;
  logic                               in_ready;
  logic                               restart;
  logic                               out_valid;
  logic                               out_ready;
  logic [im2col_pkg::FIELD_W-1:0]     src_channel;
  logic [im2col_pkg::FIELD_W-1:0]     src_row;
  logic [im2col_pkg::FIELD_W-1:0]     src_col;
  logic [im2col_pkg::ADDR_W-1:0]      src_address;
  logic [im2col_pkg::LOWER_W-1:0]     dst_row;
  logic [im2col_pkg::LOWER_W-1:0]     dst_col;
  logic                               patch_done;
  logic                               matrix_done;
  logic                               config_error;

  im2col_patch_address_generator_top DUT (.*);

  // Predictor copy of the registers and the walk counters.
  logic [im2col_pkg::MAP_REG_W-1:0]  reg_channels, reg_height, reg_width;
  logic [im2col_pkg::KERN_REG_W-1:0] reg_krows, reg_kcols;
  int walk_orow, walk_ocol, walk_chan, walk_krow, walk_kcol, walk_lrow, walk_lcol;

  gather_elem_t pending_elems[$];
  stim_row_t    script[$];
  int  mismatches, words_in, results_seen, matrix_wraps, error_results, reg_writes;
  int  quiet_cycles;
  bit  steady;

  function automatic int eff_size(int v, int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function void clear_walk();
    walk_orow = 0;
    walk_ocol = 0;
    walk_chan = 0;
    walk_krow = 0;
    walk_kcol = 0;
    walk_lrow = 0;
    walk_lcol = 0;
  endfunction

  function automatic gather_elem_t next_gather_elem(bit from_start);
    int ch, h, w, kr, kc, oh, ow;
    bit lkc, lkr, lch, loc, lor, pd, md;
    longint unsigned srow, scol, addr;
    gather_elem_t e;
    ch = eff_size(reg_channels, im2col_pkg::DEF_MAX_CHANNELS);
    h  = eff_size(reg_height, im2col_pkg::DEF_MAX_MAP_DIM);
    w  = eff_size(reg_width, im2col_pkg::DEF_MAX_MAP_DIM);
    kr = eff_size(reg_krows, im2col_pkg::DEF_MAX_KERNEL_DIM);
    kc = eff_size(reg_kcols, im2col_pkg::DEF_MAX_KERNEL_DIM);
    oh = (h >= kr) ? h - kr + 1 : 1;
    ow = (w >= kc) ? w - kc + 1 : 1;
    if (from_start) clear_walk();
    // A counter left past its last value by a register change counts as last.
    lkc = walk_kcol >= kc - 1;
    lkr = walk_krow >= kr - 1;
    lch = walk_chan >= ch - 1;
    loc = walk_ocol >= ow - 1;
    lor = walk_orow >= oh - 1;
    pd  = lkc && lkr && lch;
    md  = pd && loc && lor;
    srow = longint'(walk_orow) + walk_krow;
    scol = longint'(walk_ocol) + walk_kcol;
    addr = (longint'(walk_chan) * h + srow) * w + scol;
    e.src_channel  = im2col_pkg::FIELD_W'(walk_chan);
    e.src_row      = im2col_pkg::FIELD_W'(srow);
    e.src_col      = im2col_pkg::FIELD_W'(scol);
    e.src_address  = im2col_pkg::ADDR_W'(addr);
    e.dst_row      = im2col_pkg::LOWER_W'(walk_lrow);
    e.dst_col      = im2col_pkg::LOWER_W'(walk_lcol);
    e.patch_done   = pd;
    e.matrix_done  = md;
    e.config_error = (kr > h) || (kc > w);
    if (md) begin
      clear_walk();
    end else if (pd) begin
      walk_kcol = 0;
      walk_krow = 0;
      walk_chan = 0;
      walk_lrow = 0;
      walk_lcol = (walk_lcol + 1) & 16'hFFFF;
      if (loc) begin
        walk_ocol = 0;
        walk_orow++;
      end else begin
        walk_ocol++;
      end
    end else begin
      walk_lrow = (walk_lrow + 1) & 16'hFFFF;
      if (!lkc) begin
        walk_kcol++;
      end else begin
        walk_kcol = 0;
        if (!lkr) begin
          walk_krow++;
        end else begin
          walk_krow = 0;
          walk_chan++;
        end
      end
    end
    return e;
  endfunction

  // Mostly small sizes so the walk wraps often; now and then zero, the
  // maximum, or a value past the maximum.
  function automatic logic [im2col_pkg::CFG_DATA_W-1:0] pick_size(int small_hi, int hi);
    case ($urandom_range(0, 11))
      0: return '0;
      1: return im2col_pkg::CFG_DATA_W'(hi);
      2: return im2col_pkg::CFG_DATA_W'($urandom_range(hi + 1, 511));
      3: return im2col_pkg::CFG_DATA_W'($urandom_range(0, 511));
      default: return im2col_pkg::CFG_DATA_W'($urandom_range(1, small_hi));
    endcase
  endfunction

  task automatic write_reg(logic [im2col_pkg::CFG_INDEX_W-1:0] idx,
                           logic [im2col_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    case (idx)
      im2col_pkg::REG_CHANNEL_COUNT: reg_channels = data[im2col_pkg::MAP_REG_W-1:0];
      im2col_pkg::REG_MAP_HEIGHT:    reg_height   = data[im2col_pkg::MAP_REG_W-1:0];
      im2col_pkg::REG_MAP_WIDTH:     reg_width    = data[im2col_pkg::MAP_REG_W-1:0];
      im2col_pkg::REG_KERNEL_ROWS:   reg_krows    = data[im2col_pkg::KERN_REG_W-1:0];
      im2col_pkg::REG_KERNEL_COLS:   reg_kcols    = data[im2col_pkg::KERN_REG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_item(bit from_start, bit typed, gather_elem_t want);
    gather_elem_t e;
    int gap;
    cfg_valid <= 1'b0;
    in_valid  <= 1'b1;
    restart   <= from_start;
    do @(posedge clk); while (!in_ready);
    words_in++;
    e = next_gather_elem(from_start);
    pending_elems.push_back(typed ? want : e);
    gap = 0;
    if (!steady) begin
      case ($urandom_range(0, 19))
        0: gap = $urandom_range(10, 30);
        1, 2, 3, 4, 5, 6: gap = $urandom_range(1, 3);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Registers may only change once every word in flight has come out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    gather_elem_t w;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (matrix_done) matrix_wraps++;
      if (config_error) error_results++;
      if (pending_elems.size() == 0) begin
        mismatches++;
        $display("%0t: result word with nothing pending, src_address %0h",
                 $time, src_address);
      end else begin
        w = pending_elems.pop_front();
        check_field("src_channel", w.src_channel, src_channel);
        check_field("src_row", w.src_row, src_row);
        check_field("src_col", w.src_col, src_col);
        check_field("src_address", w.src_address, src_address);
        check_field("dst_row", w.dst_row, dst_row);
        check_field("dst_col", w.dst_col, dst_col);
        check_field("patch_done", w.patch_done, patch_done);
        check_field("matrix_done", w.matrix_done, matrix_done);
        check_field("config_error", w.config_error, config_error);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, long ready stretches, and one long hold-off
  // while the sender is offering so the block backs up into in_ready.
  initial begin
    int run, gap;
    bit held;
    held = 1'b0;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && results_seen >= 400 && in_valid) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end
      out_ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
      repeat (run) @(posedge clk);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    int n, random_words;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = im2col_pkg::REG_CHANNEL_COUNT;
    cfg_data = '0;
    in_valid = 1'b0;
    restart = 1'b0;
    steady = 1'b0;
    random_words = 0;
    reg_channels = 1;
    reg_height = 1;
    reg_width = 1;
    reg_krows = 1;
    reg_kcols = 1;
    clear_walk();

    script.push_back('{1'b0, im2col_pkg::REG_CHANNEL_COUNT, 9'd0, 1'b0, 1'b1, ORIGIN_ELEM});
    script.push_back('{1'b0, im2col_pkg::REG_CHANNEL_COUNT, 9'd0, 1'b1, 1'b1, ORIGIN_ELEM});
    script.push_back('{1'b0, im2col_pkg::REG_CHANNEL_COUNT, 9'd0, 1'b0, 1'b1, ORIGIN_ELEM});
    // A zero register behaves as one.
    script.push_back('{1'b1, im2col_pkg::REG_MAP_HEIGHT, 9'd0, 1'b0, 1'b0, NO_ELEM});
    script.push_back('{1'b0, im2col_pkg::REG_CHANNEL_COUNT, 9'd0, 1'b0, 1'b1, ORIGIN_ELEM});
    script.push_back('{1'b1, im2col_pkg::REG_KERNEL_ROWS, 9'd2, 1'b0, 1'b0, NO_ELEM});
    script.push_back('{1'b0, im2col_pkg::REG_CHANNEL_COUNT, 9'd0, 1'b0, 1'b1,
                       TALL_TOP_ELEM});
    script.push_back('{1'b0, im2col_pkg::REG_CHANNEL_COUNT, 9'd0, 1'b0, 1'b1,
                       TALL_BOTTOM_ELEM});
    script.push_back('{1'b1, im2col_pkg::REG_KERNEL_ROWS, 9'd1, 1'b0, 1'b0, NO_ELEM});
    script.push_back('{1'b1, im2col_pkg::REG_KERNEL_COLS, 9'd31, 1'b0, 1'b0, NO_ELEM});
    repeat (3)
      script.push_back('{1'b0, im2col_pkg::REG_CHANNEL_COUNT, 9'd0, 1'b0, 1'b0, NO_ELEM});
    // Every register at or past its maximum, changed in the middle of a walk.
    script.push_back('{1'b1, im2col_pkg::REG_CHANNEL_COUNT, 9'd511, 1'b0, 1'b0, NO_ELEM});
    script.push_back('{1'b1, im2col_pkg::REG_MAP_HEIGHT, 9'd256, 1'b0, 1'b0, NO_ELEM});
    script.push_back('{1'b1, im2col_pkg::REG_MAP_WIDTH, 9'd300, 1'b0, 1'b0, NO_ELEM});
    script.push_back('{1'b1, im2col_pkg::REG_KERNEL_ROWS, 9'd16, 1'b0, 1'b0, NO_ELEM});
    script.push_back('{1'b1, im2col_pkg::REG_KERNEL_COLS, 9'd16, 1'b0, 1'b0, NO_ELEM});
    repeat (4)
      script.push_back('{1'b0, im2col_pkg::REG_CHANNEL_COUNT, 9'd0, 1'b0, 1'b0, NO_ELEM});
    script.push_back('{1'b0, im2col_pkg::REG_CHANNEL_COUNT, 9'd0, 1'b1, 1'b0, NO_ELEM});
    repeat (2)
      script.push_back('{1'b0, im2col_pkg::REG_CHANNEL_COUNT, 9'd0, 1'b0, 1'b0, NO_ELEM});
    // One-by-one kernel over 256 channels walks straight through the channels.
    script.push_back('{1'b1, im2col_pkg::REG_KERNEL_ROWS, 9'd0, 1'b0, 1'b0, NO_ELEM});
    script.push_back('{1'b1, im2col_pkg::REG_KERNEL_COLS, 9'd0, 1'b0, 1'b0, NO_ELEM});
    repeat (3)
      script.push_back('{1'b0, im2col_pkg::REG_CHANNEL_COUNT, 9'd0, 1'b0, 1'b0, NO_ELEM});
    script.push_back('{1'b1, im2col_pkg::REG_KERNEL_ROWS, 9'd20, 1'b0, 1'b0, NO_ELEM});
    script.push_back('{1'b1, im2col_pkg::REG_KERNEL_COLS, 9'h1E3, 1'b0, 1'b0, NO_ELEM});
    repeat (2)
      script.push_back('{1'b0, im2col_pkg::REG_CHANNEL_COUNT, 9'd0, 1'b0, 1'b0, NO_ELEM});
    script.push_back('{1'b1, REG_UNUSED, 9'd5, 1'b0, 1'b0, NO_ELEM});
    script.push_back('{1'b0, im2col_pkg::REG_CHANNEL_COUNT, 9'd0, 1'b1, 1'b0, NO_ELEM});
    script.push_back('{1'b0, im2col_pkg::REG_CHANNEL_COUNT, 9'd0, 1'b0, 1'b0, NO_ELEM});

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        wait_idle();
        write_reg(script[i].idx, script[i].data);
      end else begin
        send_item(script[i].from_start, script[i].typed, script[i].want);
      end
    end

    while (random_words < RANDOM_WORDS) begin
      wait_idle();
      if ($urandom_range(0, 3) != 0)
        write_reg(im2col_pkg::REG_CHANNEL_COUNT, pick_size(3, 256));
      if ($urandom_range(0, 3) != 0)
        write_reg(im2col_pkg::REG_MAP_HEIGHT, pick_size(8, 256));
      if ($urandom_range(0, 3) != 0)
        write_reg(im2col_pkg::REG_MAP_WIDTH, pick_size(8, 256));
      if ($urandom_range(0, 3) != 0)
        write_reg(im2col_pkg::REG_KERNEL_ROWS, pick_size(4, 16));
      if ($urandom_range(0, 3) != 0)
        write_reg(im2col_pkg::REG_KERNEL_COLS, pick_size(4, 16));
      steady = ($urandom_range(0, 3) == 0);
      n = $urandom_range(20, 80);
      repeat (n) begin
        send_item($urandom_range(0, 15) == 0, 1'b0, NO_ELEM);
        random_words++;
      end
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (pending_elems.size() != 0) begin
      mismatches++;
      $display("%0t: %0d results never arrived", $time, pending_elems.size());
    end
    $display("Sent %0d words and checked %0d results over %0d register writes.",
             words_in, results_seen, reg_writes);
    $display("Saw %0d full matrix wraps and %0d results with config_error set.",
             matrix_wraps, error_results);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/im2col_pkg.sv
design/im2col_cfg.sv
design/im2col_walk.sv
design/im2col_addr.sv
design/im2col_patch_address_generator_top.sv
tb/tb.sv
